[hdl/betc_pkg.sv]
`default_nettype none

package betc_pkg;

	localparam int GRAY_W      = 8;
	localparam int GRAY_BITS_DEF = 8;
	localparam int NUM_FILTERS = 5;
	localparam int FLAG_W      = NUM_FILTERS + 1;
	localparam int COUNT_W     = 3;
	localparam int PEAK_W      = 18;
	localparam int NONEDGE_W   = 10;
	localparam int RATIO_W     = 9;
	localparam int CFG_DATA_W  = 10;
	localparam int CFG_IDX_W   = 2;

	// sqrt(2) in Q.8
	localparam int SQRT2_Q8 = 362;

	// Filter order inside the response vector
	localparam int F_NONDIR    = 0;
	localparam int F_HORIZ     = 1;
	localparam int F_VERT      = 2;
	localparam int F_DIAG      = 3;
	localparam int F_ANTIDIAG  = 4;

	// Flag bit of the no-edge type; filter f sits at bit f + 1
	localparam int FLAG_NO_EDGE = 0;

	localparam logic [NONEDGE_W-1:0] T_NONEDGE_RST        = 10'd14;
	localparam logic [RATIO_W-1:0]   T_NONDIRECTIONAL_RST = 9'd174;
	localparam logic [RATIO_W-1:0]   T_STRAIGHT_RST       = 9'd251;
	localparam logic [RATIO_W-1:0]   T_DIAGONAL_RST       = 9'd251;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_T_NONEDGE        = 2'd0,
		REG_T_NONDIRECTIONAL = 2'd1,
		REG_T_STRAIGHT       = 2'd2,
		REG_T_DIAGONAL       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [NONEDGE_W-1:0] t_nonedge;
		logic [RATIO_W-1:0]   t_nondirectional;
		logic [RATIO_W-1:0]   t_straight;
		logic [RATIO_W-1:0]   t_diagonal;
	} cfg_t;

	typedef struct packed {
		logic [GRAY_W-1:0] gray_top_left;
		logic [GRAY_W-1:0] gray_top_right;
		logic [GRAY_W-1:0] gray_bottom_left;
		logic [GRAY_W-1:0] gray_bottom_right;
	} in_item_t;

	typedef struct packed {
		logic [FLAG_W-1:0]  edge_flags;
		logic [COUNT_W-1:0] edge_count;
		logic [PEAK_W-1:0]  peak_response;
	} out_item_t;

endpackage

`default_nettype wire

[hdl/betc_filter.sv]
`default_nettype none

module betc_filter #(
	parameter int GRAY_BITS = betc_pkg::GRAY_BITS_DEF
) (
	input  wire betc_pkg::in_item_t                       quad,
	output logic [betc_pkg::NUM_FILTERS-1:0][GRAY_BITS+9:0] resp,
	output logic [GRAY_BITS+9:0]                          peak
);

	localparam int PW = GRAY_BITS + 10;
	localparam int SW = GRAY_BITS + 3;

	logic signed [SW-1:0] a, b, c, d;
	logic signed [SW-1:0] sum_nd, sum_h, sum_v, dif_d, dif_a;
	logic [SW-1:0] mag_nd, mag_h, mag_v, mag_d, mag_a;
	logic [PW-1:0] max_01, max_23, max_03;

	assign a = $signed(SW'(GRAY_BITS'(quad.gray_top_left)));
	assign b = $signed(SW'(GRAY_BITS'(quad.gray_top_right)));
	assign c = $signed(SW'(GRAY_BITS'(quad.gray_bottom_left)));
	assign d = $signed(SW'(GRAY_BITS'(quad.gray_bottom_right)));

	assign sum_nd = a - b - c + d;
	assign sum_h  = a + b - c - d;
	assign sum_v  = a - b + c - d;
	assign dif_d  = a - d;
	assign dif_a  = b - c;

	assign mag_nd = sum_nd[SW-1] ? SW'(-sum_nd) : SW'(sum_nd);
	assign mag_h  = sum_h[SW-1]  ? SW'(-sum_h)  : SW'(sum_h);
	assign mag_v  = sum_v[SW-1]  ? SW'(-sum_v)  : SW'(sum_v);
	assign mag_d  = dif_d[SW-1]  ? SW'(-dif_d)  : SW'(dif_d);
	assign mag_a  = dif_a[SW-1]  ? SW'(-dif_a)  : SW'(dif_a);

	// The non-directional kernel has weight two, hence the extra shift.
	assign resp[betc_pkg::F_NONDIR]   = PW'(mag_nd) << 9;
	assign resp[betc_pkg::F_HORIZ]    = PW'(mag_h) << 8;
	assign resp[betc_pkg::F_VERT]     = PW'(mag_v) << 8;
	assign resp[betc_pkg::F_DIAG]     = PW'(mag_d) * PW'(betc_pkg::SQRT2_Q8);
	assign resp[betc_pkg::F_ANTIDIAG] = PW'(mag_a) * PW'(betc_pkg::SQRT2_Q8);

	always_comb begin
		max_01 = (resp[0] > resp[1]) ? resp[0] : resp[1];
		max_23 = (resp[2] > resp[3]) ? resp[2] : resp[3];
		max_03 = (max_01 > max_23) ? max_01 : max_23;
		peak   = (max_03 > resp[4]) ? max_03 : resp[4];
	end

endmodule

`default_nettype wire

[hdl/betc_classify.sv]
`default_nettype none

module betc_classify #(
	parameter int GRAY_BITS = betc_pkg::GRAY_BITS_DEF
) (
	input  wire  [betc_pkg::NUM_FILTERS-1:0][GRAY_BITS+9:0] resp,
	input  wire  [GRAY_BITS+9:0]                            peak,
	input  wire  betc_pkg::cfg_t                            cfg,
	output betc_pkg::out_item_t                             item
);

	localparam int PW    = GRAY_BITS + 10;
	localparam int MW    = PW + betc_pkg::RATIO_W;
	localparam int CW    = (PW > betc_pkg::PEAK_W) ? PW : betc_pkg::PEAK_W;
	localparam int PeakW = betc_pkg::PEAK_W;
	localparam int NF    = betc_pkg::NUM_FILTERS;

	logic [NF-1:0][betc_pkg::RATIO_W-1:0] thr;
	logic [NF-1:0][MW-1:0] lhs;
	logic [NF-1:0][MW-1:0] rhs;
	logic [NF-1:0] pass;
	logic no_edge;
	logic [betc_pkg::FLAG_W-1:0] flags;
	logic [betc_pkg::COUNT_W-1:0] count;

	assign thr[betc_pkg::F_NONDIR]   = cfg.t_nondirectional;
	assign thr[betc_pkg::F_HORIZ]    = cfg.t_straight;
	assign thr[betc_pkg::F_VERT]     = cfg.t_straight;
	assign thr[betc_pkg::F_DIAG]     = cfg.t_diagonal;
	assign thr[betc_pkg::F_ANTIDIAG] = cfg.t_diagonal;

	// The no-edge threshold is an integer level, so it is scaled into Q.8.
	assign no_edge = CW'(peak) < (CW'(cfg.t_nonedge) << 8);

	// Ratio test without a division: response * 256 > t * peak.
	always_comb begin
		for (int i = 0; i < NF; i++) begin
			lhs[i]  = MW'(resp[i]) << 8;
			rhs[i]  = MW'(thr[i]) * MW'(peak);
			pass[i] = lhs[i] > rhs[i];
		end
	end

	always_comb begin
		flags = '0;
		if (no_edge) begin
			flags[betc_pkg::FLAG_NO_EDGE] = 1'b1;
		end else begin
			flags[NF:1] = pass;
		end
		count = '0;
		for (int i = 0; i < betc_pkg::FLAG_W; i++) begin
			count = count + betc_pkg::COUNT_W'(flags[i]);
		end
	end

	assign item.edge_flags    = flags;
	assign item.edge_count    = count;
	assign item.peak_response = PeakW'(peak);

endmodule

`default_nettype wire

[hdl/block_edge_type_classifier_core.sv]
`default_nettype none

// Edge-type classifier for 2x2-split image blocks. Each transaction on the
// quad channel carries the four quarter mean gray levels; each transaction on
// the result channel carries the edge flags, their count and the peak filter
// response in Q.8. One transaction is accepted per clock while quad_stall is
// low. Three registers sit between the ports: the input register, the filter
// and peak stage, and the ratio-threshold stage with its five threshold
// products. The matching result passes through these registers in that order
// and is presented from the last. A stall on the result side backs up
// through the three stage registers before quad_stall rises, so up to three
// transactions are held in flight. The user must write thresholds through
// the cfg port while no transaction is in flight; the block does not enforce it.
module block_edge_type_classifier_core #(
	parameter int GRAY_BITS = betc_pkg::GRAY_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   quad_valid,
	output logic                                  quad_stall,
	input  wire  betc_pkg::in_item_t              quad,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output betc_pkg::out_item_t                   result,
	input  wire                                   cfg_write,
	input  wire  [betc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [betc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int PW = GRAY_BITS + 10;
	localparam int NF = betc_pkg::NUM_FILTERS;

	betc_pkg::cfg_t cfg_q;

	logic valid_s1, valid_s2, valid_s3;
	logic en_s1, en_s2, en_s3;
	betc_pkg::in_item_t quad_s1;
	logic [NF-1:0][PW-1:0] resp, resp_s2;
	logic [PW-1:0] peak, peak_s2;
	betc_pkg::out_item_t item, result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t_nonedge        <= betc_pkg::T_NONEDGE_RST;
			cfg_q.t_nondirectional <= betc_pkg::T_NONDIRECTIONAL_RST;
			cfg_q.t_straight       <= betc_pkg::T_STRAIGHT_RST;
			cfg_q.t_diagonal       <= betc_pkg::T_DIAGONAL_RST;
		end else if (cfg_write) begin
			case (betc_pkg::cfg_reg_t'(cfg_index))
				betc_pkg::REG_T_NONEDGE: begin
					cfg_q.t_nonedge <= cfg_data;
				end
				betc_pkg::REG_T_NONDIRECTIONAL: begin
					cfg_q.t_nondirectional <= cfg_data[betc_pkg::RATIO_W-1:0];
				end
				betc_pkg::REG_T_STRAIGHT: begin
					cfg_q.t_straight <= cfg_data[betc_pkg::RATIO_W-1:0];
				end
				betc_pkg::REG_T_DIAGONAL: begin
					cfg_q.t_diagonal <= cfg_data[betc_pkg::RATIO_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on this cycle.
	assign en_s3 = !valid_s3 || !result_stall;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign quad_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= quad_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && quad_valid) begin
			quad_s1 <= quad;
		end
		if (en_s2 && valid_s1) begin
			resp_s2 <= resp;
			peak_s2 <= peak;
		end
		if (en_s3 && valid_s2) begin
			result_s3 <= item;
		end
	end

	betc_filter #(
		.GRAY_BITS(GRAY_BITS)
	) u_filter (
		.quad(quad_s1),
		.resp(resp),
		.peak(peak)
	);

	betc_classify #(
		.GRAY_BITS(GRAY_BITS)
	) u_classify (
		.resp(resp_s2),
		.peak(peak_s2),
		.cfg(cfg_q),
		.item(item)
	);

	assign result_valid = valid_s3;
	assign result       = result_s3;

`ifndef SYNTHESIS
	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(result.edge_count) == $countones(result.edge_flags)))
		else $error("edge_count does not match the number of set flags");

	a_no_edge_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.edge_flags[betc_pkg::FLAG_NO_EDGE])
			|-> (result.edge_flags[betc_pkg::FLAG_W-1:1] == '0))
		else $error("no-edge flag set together with a filter flag");

	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en_s2) |=> valid_s2)
		else $error("transaction lost between input register and filter stage");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		quad_stall |-> (valid_s1 && valid_s2 && valid_s3 && result_stall))
		else $error("quad channel stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire
